// ===== rtl/atlas_shelf_packer_defines.svh =====
// assertion helpers shared by the packer rtl
`ifndef ATLAS_SHELF_PACKER_DEFINES_SVH
`define ATLAS_SHELF_PACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/asp_pkg.sv =====
`timescale 1ns / 1ps

package asp_pkg;

	// field widths
	localparam int unsigned RECT_W    = 8;
	localparam int unsigned POS_W     = 14;
	localparam int unsigned COORD_W   = 15;
	localparam int unsigned ATLAS_W   = 15;
	localparam int unsigned CFG_W     = 15;
	localparam int unsigned CFG_IDX_W = 2;

	// defaults
	localparam int unsigned MAX_ATLAS_DIM_DEF = 16384;
	localparam int unsigned CFG_DIM_RESET     = 256;
	localparam int unsigned GROW_FACTOR       = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_HEIGHT = 2'd1;

	// packing order of the quadrants
	typedef enum logic [1:0] {
		QUAD_TL,
		QUAD_TR,
		QUAD_BL,
		QUAD_BR
	} asp_quad_t;

	// one placement result
	typedef struct packed {
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic               grew;
		logic [ATLAS_W-1:0] atlas_width;
		logic [ATLAS_W-1:0] atlas_height;
		logic               full_res;
	} asp_result_t;

endpackage

// ===== rtl/atlas_shelf_packer.sv =====
`timescale 1ns / 1ps

// Shelf packer for a texture atlas. Each input beat carries one rectangle
// size and yields one result beat with its position, the atlas size after
// the placement, a grew flag and a full flag. One rectangle is taken every
// cycle while in_stall is low. A beat passes an input register, then the
// placement logic (a few adds and compares against the shelf and quadrant
// anchors), whose state is updated in the same cycle the result register
// loads. Writing either size register restarts packing with the new initial
// atlas size; the user must write only while idle; the block does not check.

`include "atlas_shelf_packer_defines.svh"

module atlas_shelf_packer import asp_pkg::*; #(
	parameter int unsigned MAX_ATLAS_DIM = MAX_ATLAS_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [RECT_W-1:0]    rect_width,
	input  logic [RECT_W-1:0]    rect_height,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [POS_W-1:0]     pos_x,
	output logic [POS_W-1:0]     pos_y,
	output logic                 grew,
	output logic [ATLAS_W-1:0]   atlas_width,
	output logic [ATLAS_W-1:0]   atlas_height,
	output logic                 full_res
);

	logic              valid_s1, valid_s2;
	logic [RECT_W-1:0] width_s1, height_s1;
	asp_result_t       result_s2;
	asp_result_t       placed;
	logic              advance;

	// stage handshake: input beat moves to the result register when it is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	asp_core #(
		.MAX_ATLAS_DIM(MAX_ATLAS_DIM)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.step       (advance),
		.rect_width (width_s1),
		.rect_height(height_s1),
		.result     (placed)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			width_s1  <= rect_width;
			height_s1 <= rect_height;
		end
		if (advance) begin
			result_s2 <= placed;
		end
	end

	assign out_valid    = valid_s2;
	assign pos_x        = result_s2.pos_x;
	assign pos_y        = result_s2.pos_y;
	assign grew         = result_s2.grew;
	assign atlas_width  = result_s2.atlas_width;
	assign atlas_height = result_s2.atlas_height;
	assign full_res     = result_s2.full_res;

	// result and pipeline checks
	`ASP_ASSERT_IMPL(a_full_clean, out_valid && full_res,
		!grew && pos_x == '0 && pos_y == '0,
		"full result carries a position or a grew flag")
	`ASP_ASSERT_IMPL(a_stall_only_busy, in_stall, valid_s1 && valid_s2,
		"input stalled with a free stage")
	`ASP_ASSERT_NEXT(a_advance_fills, advance, valid_s2,
		"advanced beat did not reach the result register")

endmodule

// ===== rtl/asp_core.sv =====
`timescale 1ns / 1ps

`include "atlas_shelf_packer_defines.svh"

module asp_core import asp_pkg::*; #(
	parameter int unsigned MAX_ATLAS_DIM = MAX_ATLAS_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 step,
	input  logic [RECT_W-1:0]    rect_width,
	input  logic [RECT_W-1:0]    rect_height,
	output asp_result_t          result
);

	localparam int unsigned DIM_W = $clog2(MAX_ATLAS_DIM + 1);
	localparam int unsigned CMP_W = ((DIM_W > COORD_W + 1) ? DIM_W : COORD_W + 1) + 1;
	localparam logic [DIM_W-1:0] MAX_DIM   = DIM_W'(MAX_ATLAS_DIM);
	localparam logic [DIM_W-1:0] HALF_MAX  = DIM_W'(MAX_ATLAS_DIM / GROW_FACTOR);
	localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(CFG_DIM_RESET);
	localparam logic [DIM_W-1:0] ONE_DIM   = DIM_W'(1);

	// packer state
	logic [DIM_W-1:0]   init_w_q, init_h_q;
	logic [COORD_W-1:0] cursor_x_q, cursor_y_q, line_x_q, line_y_q;
	logic [DIM_W-1:0]   quad_x_q, quad_y_q, quad_w_q, quad_h_q;
	logic [DIM_W-1:0]   size_w_q, size_h_q;
	asp_quad_t          quad_q;

	// next-state values
	logic [COORD_W-1:0] cursor_x_d, cursor_y_d, line_x_d, line_y_d;
	logic [DIM_W-1:0]   quad_x_d, quad_y_d, quad_w_d, quad_h_d;
	logic [DIM_W-1:0]   size_w_d, size_h_d;
	asp_quad_t          quad_d;
	logic               refuse;

	// placement datapath
	logic [CMP_W-1:0]   w_x, h_x, reach_x, limit_x, limit_y, bot_x, line_y_x, ly_x;
	logic [COORD_W-1:0] rx, ry;
	logic               wrap, leave, grow;
	asp_quad_t          nq;
	logic [DIM_W-1:0]   half_w, half_h, ax, ay;
	logic [DIM_W-1:0]   clamped;
	logic [CMP_W-1:0]   ax_w, ay_h;

	// clamp of a register write to the legal size range
	always_comb begin
		if (cfg_wr_data == '0) begin
			clamped = ONE_DIM;
		end else if (32'(cfg_wr_data) > 32'(MAX_ATLAS_DIM)) begin
			clamped = MAX_DIM;
		end else begin
			clamped = DIM_W'(cfg_wr_data);
		end
	end

	// shelf placement and quadrant step
	always_comb begin
		w_x      = CMP_W'(rect_width);
		h_x      = CMP_W'(rect_height);
		line_y_x = CMP_W'(line_y_q);
		reach_x  = CMP_W'(cursor_x_q) + w_x;
		limit_x  = CMP_W'(quad_x_q) + CMP_W'(quad_w_q);
		limit_y  = CMP_W'(quad_y_q) + CMP_W'(quad_h_q);
		wrap     = reach_x >= limit_x;
		rx       = wrap ? line_x_q : cursor_x_q;
		ry       = wrap ? line_y_q : cursor_y_q;
		bot_x    = CMP_W'(ry) + h_x;
		ly_x     = (bot_x > line_y_x) ? bot_x : line_y_x;
		leave    = ly_x >= limit_y;

		unique case (quad_q)
			QUAD_TL: begin nq = QUAD_TR; grow = 1'b1; end
			QUAD_TR: begin nq = QUAD_BL; grow = 1'b0; end
			QUAD_BL: begin nq = QUAD_BR; grow = 1'b0; end
			QUAD_BR: begin nq = QUAD_TR; grow = 1'b1; end
			default: begin nq = QUAD_TR; grow = 1'b1; end
		endcase

		refuse = leave && grow && ((size_w_q > HALF_MAX) || (size_h_q > HALF_MAX));

		// after a doubling the old atlas size is the new half size
		half_w = (leave && grow) ? size_w_q : (size_w_q >> 1);
		half_h = (leave && grow) ? size_h_q : (size_h_q >> 1);

		unique case (nq)
			QUAD_TR: begin ax = half_w; ay = '0;     end
			QUAD_BL: begin ax = '0;     ay = half_h; end
			default: begin ax = half_w; ay = half_h; end
		endcase
		ax_w = CMP_W'(ax) + w_x;
		ay_h = CMP_W'(ay) + h_x;

		// defaults: stay on the current quadrant
		cursor_x_d = COORD_W'(CMP_W'(rx) + w_x);
		cursor_y_d = ry;
		line_x_d   = line_x_q;
		line_y_d   = ly_x[COORD_W-1:0];
		quad_x_d   = quad_x_q;
		quad_y_d   = quad_y_q;
		quad_w_d   = quad_w_q;
		quad_h_d   = quad_h_q;
		size_w_d   = size_w_q;
		size_h_d   = size_h_q;
		quad_d     = quad_q;

		result.pos_x        = rx[POS_W-1:0];
		result.pos_y        = ry[POS_W-1:0];
		result.grew         = 1'b0;
		result.full_res     = 1'b0;

		if (refuse) begin
			// atlas full: nothing moves
			cursor_x_d      = cursor_x_q;
			cursor_y_d      = cursor_y_q;
			line_y_d        = line_y_q;
			result.pos_x    = '0;
			result.pos_y    = '0;
			result.full_res = 1'b1;
		end else if (leave) begin
			if (grow) begin
				size_w_d    = DIM_W'({size_w_q, 1'b0});
				size_h_d    = DIM_W'({size_h_q, 1'b0});
				quad_w_d    = size_w_q;
				quad_h_d    = size_h_q;
				result.grew = 1'b1;
			end
			quad_d       = nq;
			quad_x_d     = ax;
			quad_y_d     = ay;
			cursor_x_d   = ax_w[COORD_W-1:0];
			cursor_y_d   = COORD_W'(CMP_W'(ay));
			line_x_d     = COORD_W'(CMP_W'(ax));
			line_y_d     = ay_h[COORD_W-1:0];
			result.pos_x = ax_w[POS_W-1:0] - w_x[POS_W-1:0];
			result.pos_y = ay_h[POS_W-1:0] - h_x[POS_W-1:0];
		end

		result.atlas_width  = ATLAS_W'(size_w_d);
		result.atlas_height = ATLAS_W'(size_h_d);
	end

	// state registers; a register write restarts packing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_w_q   <= RESET_DIM;
			init_h_q   <= RESET_DIM;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_x_q   <= '0;
			line_y_q   <= '0;
			quad_x_q   <= '0;
			quad_y_q   <= '0;
			quad_w_q   <= RESET_DIM;
			quad_h_q   <= RESET_DIM;
			size_w_q   <= RESET_DIM;
			size_h_q   <= RESET_DIM;
			quad_q     <= QUAD_TL;
		end else if (cfg_wr_en && (cfg_index == REG_INITIAL_WIDTH ||
				cfg_index == REG_INITIAL_HEIGHT)) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_x_q   <= '0;
			line_y_q   <= '0;
			quad_x_q   <= '0;
			quad_y_q   <= '0;
			quad_q     <= QUAD_TL;
			if (cfg_index == REG_INITIAL_WIDTH) begin
				init_w_q <= clamped;
				quad_w_q <= clamped;
				size_w_q <= clamped;
				quad_h_q <= init_h_q;
				size_h_q <= init_h_q;
			end else begin
				init_h_q <= clamped;
				quad_h_q <= clamped;
				size_h_q <= clamped;
				quad_w_q <= init_w_q;
				size_w_q <= init_w_q;
			end
		end else if (step) begin
			cursor_x_q <= cursor_x_d;
			cursor_y_q <= cursor_y_d;
			line_x_q   <= line_x_d;
			line_y_q   <= line_y_d;
			quad_x_q   <= quad_x_d;
			quad_y_q   <= quad_y_d;
			quad_w_q   <= quad_w_d;
			quad_h_q   <= quad_h_d;
			size_w_q   <= size_w_d;
			size_h_q   <= size_h_d;
			quad_q     <= quad_d;
		end
	end

	// checks on the packer state
	`ASP_ASSERT_NEXT(a_refuse_holds, step && refuse && !cfg_wr_en,
		$stable(size_w_q) && $stable(quad_q) && $stable(cursor_x_q),
		"refused doubling changed the packer state")
	`ASP_ASSERT_NEXT(a_grow_doubles, step && !refuse && leave && grow && !cfg_wr_en,
		size_w_q == DIM_W'({$past(size_w_q), 1'b0}) && quad_q == QUAD_TR,
		"doubling did not double the atlas or land in the top-right quadrant")
	`ASP_ASSERT_IMPL(a_size_limit, 1'b1,
		size_w_q <= MAX_DIM && size_h_q <= MAX_DIM && size_w_q != '0,
		"atlas size out of range")

endmodule
